### design/gbhp_pkg.sv
// Shared types, constants and helpers for the geometry blob header parser.
package gbhp_pkg;

  localparam logic [7:0] MAGIC_FIRST  = 8'h47;
  localparam logic [7:0] MAGIC_SECOND = 8'h50;
  localparam logic [7:0] VERSION_ZERO = 8'h00;
  localparam logic [2:0] ENV_CODE_MASK = 3'h7;
  localparam logic [7:0] ORDER_BIT    = 8'h01;

  localparam logic [6:0] POS_MAGIC2  = 7'd1;
  localparam logic [6:0] POS_VERSION = 7'd2;
  localparam logic [6:0] POS_FLAGS   = 7'd3;
  localparam logic [6:0] POS_BOUNDS  = 7'd8;

  localparam logic [2:0] ENV_NONE = 3'd0;
  localparam logic [2:0] ENV_XY   = 3'd1;
  localparam logic [2:0] ENV_XYZ  = 3'd2;
  localparam logic [2:0] ENV_XYM  = 3'd3;
  localparam logic [2:0] ENV_XYZM = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MAGIC = 2'd1,
    STAT_ENV   = 2'd2,
    STAT_TRUNC = 2'd3
  } status_t;

  typedef logic [5:0][63:0] bounds_t;

  typedef struct packed {
    status_t            status;
    logic               is_empty;
    logic               is_extended;
    logic               little_endian;
    logic [2:0]         envelope_code;
    logic signed [31:0] srs_id;
    bounds_t            bounds;
  } result_t;

  function automatic logic [6:0] hdr_last(input logic [2:0] code);
    logic [6:0] pos;
    case (code) inside
      ENV_XY:           pos = 7'd39;
      ENV_XYZ, ENV_XYM: pos = 7'd55;
      ENV_XYZM:         pos = 7'd71;
      default:          pos = 7'd7;
    endcase
    return pos;
  endfunction

endpackage

### design/gbhp_parse.sv
// Byte-wise header decoder: per-blob state and result formation.
module gbhp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              res_valid,
  output gbhp_pkg::result_t res
);
  import gbhp_pkg::*;

  logic [6:0]  byte_count, byte_count_next;
  logic        skip_rest, skip_rest_next;
  logic [7:0]  flag_byte, flag_byte_next;
  logic [31:0] srs_accum, srs_accum_next;
  logic [63:0] word_gather, word_gather_next;
  bounds_t     env_store, env_store_next;

  logic        hit;
  status_t     stat;
  logic        little;
  logic [2:0]  code;
  logic [3:0]  slot;
  logic [2:0]  idx;
  logic        keep;

  always_comb begin
    byte_count_next  = byte_count;
    skip_rest_next   = skip_rest;
    flag_byte_next   = flag_byte;
    srs_accum_next   = srs_accum;
    word_gather_next = word_gather;
    env_store_next   = env_store;
    hit       = 1'b0;
    stat      = STAT_OK;
    res_valid = 1'b0;
    res       = '0;
    little    = (flag_byte & ORDER_BIT) != 8'h00;
    code      = flag_byte[3:1] & ENV_CODE_MASK;
    slot      = byte_count[6:3] - 4'd1;
    idx       = slot[2:0];
    keep      = (idx < 3'd4) || ((idx < 3'd6) && (code == ENV_XYZ || code == ENV_XYZM));

    if (in_fire) begin
      if (skip_rest) begin
        if (last_byte) begin
          skip_rest_next = 1'b0;
        end
      end else begin
        if (byte_count == 7'd0) begin
          if (data_byte != MAGIC_FIRST) begin
            hit  = 1'b1;
            stat = STAT_MAGIC;
          end
        end else if (byte_count == POS_MAGIC2) begin
          if (data_byte != MAGIC_SECOND) begin
            hit  = 1'b1;
            stat = STAT_MAGIC;
          end
        end else if (byte_count == POS_VERSION) begin
          if (data_byte != VERSION_ZERO) begin
            hit  = 1'b1;
            stat = STAT_MAGIC;
          end
        end else if (byte_count == POS_FLAGS) begin
          flag_byte_next = data_byte;
          if (data_byte[3:1] > ENV_XYZM) begin
            hit  = 1'b1;
            stat = STAT_ENV;
          end
        end else begin
          if (byte_count < POS_BOUNDS) begin
            if (little) begin
              srs_accum_next = srs_accum | ({24'h0, data_byte} << {byte_count[1:0], 3'b000});
            end else begin
              srs_accum_next = {srs_accum[23:0], data_byte};
            end
          end else begin
            if (little) begin
              word_gather_next = word_gather
                                 | ({56'h0, data_byte} << {byte_count[2:0], 3'b000});
            end else begin
              word_gather_next = {word_gather[55:0], data_byte};
            end
            if (byte_count[2:0] == 3'd7) begin
              for (int i = 0; i < 6; i++) begin
                if (keep && idx == 3'(i)) begin
                  env_store_next[i] = word_gather_next;
                end
              end
              word_gather_next = '0;
            end
          end
          if (byte_count >= hdr_last(code)) begin
            hit  = 1'b1;
            stat = STAT_OK;
          end
        end

        if (!hit && last_byte) begin
          hit  = 1'b1;
          stat = STAT_TRUNC;
        end

        if (hit) begin
          res_valid         = 1'b1;
          res.status        = stat;
          if (stat != STAT_MAGIC) begin
            res.is_empty      = flag_byte_next[4];
            res.is_extended   = flag_byte_next[5];
            res.little_endian = flag_byte_next[0];
            res.envelope_code = flag_byte_next[3:1];
          end
          if (stat == STAT_OK) begin
            res.srs_id = srs_accum_next;
            res.bounds = env_store_next;
          end
          byte_count_next  = '0;
          flag_byte_next   = '0;
          srs_accum_next   = '0;
          word_gather_next = '0;
          env_store_next   = '0;
          skip_rest_next   = !last_byte;
        end else begin
          byte_count_next = byte_count + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      skip_rest   <= 1'b0;
      flag_byte   <= '0;
      srs_accum   <= '0;
      word_gather <= '0;
      env_store   <= '0;
    end else begin
      byte_count  <= byte_count_next;
      skip_rest   <= skip_rest_next;
      flag_byte   <= flag_byte_next;
      srs_accum   <= srs_accum_next;
      word_gather <= word_gather_next;
      env_store   <= env_store_next;
    end
  end

endmodule

### design/gbhp_outbuf.sv
// Two-entry result queue between the decoder and the output channel.
module gbhp_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gbhp_pkg::result_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              full,
  output gbhp_pkg::result_t head
);
  import gbhp_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] level;
  logic       pop;
  result_t    slot0, slot1;

  assign out_valid  = count != 2'd0;
  assign full       = count == 2'd2;
  assign head       = slot0;
  assign pop        = out_valid && !out_stall;
  assign level      = count - {1'b0, pop};
  assign count_next = level + {1'b0, push};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (level == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

### design/geometry_blob_header_parser_top.sv
// Top level of the geometry blob header parser.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | into      | in_valid, in_stall   | data_byte, last_byte
//  out     | out of    | out_valid, out_stall | status, flags, srs_id, six envelope bounds
//
// One byte word is taken per clock while in_stall is low; the decoder state updates in the accepting cycle.
// A result is registered into the queue on the byte that completes or breaks a header.
// A two-entry result queue decouples the channels; in_stall rises only when it is full.
// Synchronous active-high reset clears decoder state and empties the queue.
module geometry_blob_header_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               is_empty,
  output logic               is_extended,
  output logic               little_endian,
  output logic [2:0]         envelope_code,
  output logic signed [31:0] srs_id,
  output logic [63:0]        min_x,
  output logic [63:0]        max_x,
  output logic [63:0]        min_y,
  output logic [63:0]        max_y,
  output logic [63:0]        min_z,
  output logic [63:0]        max_z
);
  import gbhp_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    full;

  assign in_stall = full;
  assign in_fire  = in_valid && !in_stall;

  gbhp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  gbhp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .full      (full),
    .head      (head)
  );

  assign status        = head.status;
  assign is_empty      = head.is_empty;
  assign is_extended   = head.is_extended;
  assign little_endian = head.little_endian;
  assign envelope_code = head.envelope_code;
  assign srs_id        = head.srs_id;
  assign min_x         = head.bounds[0];
  assign max_x         = head.bounds[1];
  assign min_y         = head.bounds[2];
  assign max_y         = head.bounds[3];
  assign min_z         = head.bounds[4];
  assign max_z         = head.bounds[5];

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_magic_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_MAGIC |->
      !is_empty && !is_extended && !little_endian && envelope_code == 3'd0)
    else $error("bad magic result carries flag fields");

  a_error_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |->
      srs_id == 32'sd0 && min_x == 64'd0 && max_y == 64'd0 && max_z == 64'd0)
    else $error("error result carries header payload");

  a_env_code_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_ENV |-> envelope_code > ENV_XYZM)
    else $error("envelope error with a legal code");

  a_ok_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_OK |-> envelope_code <= ENV_XYZM)
    else $error("ok result with an illegal envelope code");

endmodule
